### hw/rtl/bpic_pkg.sv
`timescale 1ns / 1ps

package bpic_pkg;

    localparam int MaxW = 256;
    localparam int MaxH = 256;
    localparam int ColW = $clog2(MaxW);
    localparam int RowW = $clog2(MaxH);
    localparam int AddrW = ColW + RowW;
    localparam int SizeW = 9;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_CLEAN = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic REG_WIDTH = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // neighborhood slot numbering: 0 center, 1 e, 2 w, 3 n(row+1), 4 s(row-1),
    // 5 ne(c+1,r+1), 6 sw(c-1,r-1), 7 se(c+1,r-1), 8 nw(c-1,r+1)
    localparam int NbN = 9;
    localparam int SlotW = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEMOP,
        ST_CRN_RD,
        ST_CRN_WAIT,
        ST_CRN_WR,
        ST_PX_RD,
        ST_PX_WAIT,
        ST_PX_WR,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic       load_item;
        logic       clr_slot;
        logic       inc_slot;
        logic       capture;
        logic       first_corner;
        logic       next_corner;
        logic       first_px;
        logic       next_px;
        logic       calc_corner;
        logic       calc_px;
        logic       do_mem;
        logic [1:0] resp_kind;
    } t_cmd;

    typedef struct packed {
        logic slot_last;
        logic corner_last;
        logic px_last;
        logic wr_left;
    } t_sts;

    localparam logic [1:0] RESP_ITEM = 2'd0;
    localparam logic [1:0] RESP_CLEAN = 2'd1;

endpackage

### hw/rtl/binary_pore_image_cleanup.sv
`timescale 1ns / 1ps

// Bit-image store with load, read and in-place cleanup. A load or read item
// is registered first and then makes its single memory access once the
// output is free, answering with one transaction; any other command code
// answers with one transaction that has no flag set. A cleanup item settles
// the four corners and then walks the interior, reading the nine pixels of
// each neighborhood one at a time through the memory port and writing changes
// back one slot per cycle, and answers with one transaction once the output
// is free; no item is taken meanwhile.
module binary_pore_image_cleanup (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_index,
    input  logic [8:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_col,
    input  logic [7:0] i_row,
    input  logic [7:0] i_pixel_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_read_solid,
    output logic       o_op_done,
    output logic       o_out_of_range
);

    bpic_pkg::t_cmd w_cmd;
    bpic_pkg::t_sts w_sts;
    logic w_out_free;

    bpic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_cmd      (i_cmd),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_ready    (o_ready),
        .o_cmd      (w_cmd)
    );

    bpic_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index[0]),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_col          (i_col),
        .i_row          (i_row),
        .i_pixel_byte   (i_pixel_byte),
        .i_ctl          (w_cmd),
        .i_out_ready    (i_ready),
        .o_sts          (w_sts),
        .o_out_free     (w_out_free),
        .o_valid        (o_valid),
        .o_read_solid   (o_read_solid),
        .o_op_done      (o_op_done),
        .o_out_of_range (o_out_of_range)
    );

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_op_done && o_out_of_range))
        else $error("done and out of range together");

    a_rs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_read_solid) |-> o_op_done)
        else $error("read data without done");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result dropped");

endmodule

### hw/rtl/bpic_ctrl.sv
`timescale 1ns / 1ps

module bpic_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_cmd,
    input  logic              i_out_free,
    input  bpic_pkg::t_sts    i_sts,
    output logic              o_ready,
    output bpic_pkg::t_cmd    o_cmd
);

    bpic_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpic_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bpic_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_cmd == bpic_pkg::CMD_CLEAN) begin
                        n_state = bpic_pkg::ST_CRN_RD;
                    end else begin
                        n_state = bpic_pkg::ST_MEMOP;
                    end
                end
            end
            bpic_pkg::ST_MEMOP: begin
                if (i_out_free) n_state = bpic_pkg::ST_IDLE;
            end
            bpic_pkg::ST_CRN_RD: begin
                if (i_sts.slot_last) n_state = bpic_pkg::ST_CRN_WAIT;
            end
            bpic_pkg::ST_CRN_WAIT: n_state = bpic_pkg::ST_CRN_WR;
            bpic_pkg::ST_CRN_WR: begin
                if (i_sts.corner_last) n_state = bpic_pkg::ST_PX_RD;
                else n_state = bpic_pkg::ST_CRN_RD;
            end
            bpic_pkg::ST_PX_RD: begin
                if (i_sts.slot_last) n_state = bpic_pkg::ST_PX_WAIT;
            end
            bpic_pkg::ST_PX_WAIT: n_state = bpic_pkg::ST_PX_WR;
            bpic_pkg::ST_PX_WR: begin
                if (!i_sts.wr_left) begin
                    if (i_sts.px_last) n_state = bpic_pkg::ST_RESP;
                    else n_state = bpic_pkg::ST_PX_RD;
                end
            end
            bpic_pkg::ST_RESP: begin
                if (i_out_free) n_state = bpic_pkg::ST_IDLE;
            end
            default: n_state = bpic_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_ready = 1'b0;
        case (r_state)
            bpic_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                o_cmd.load_item = i_valid;
                o_cmd.clr_slot = 1'b1;
                o_cmd.first_corner = 1'b1;
                o_cmd.first_px = 1'b1;
            end
            bpic_pkg::ST_MEMOP: begin
                o_cmd.do_mem = i_out_free;
                o_cmd.resp_kind = bpic_pkg::RESP_ITEM;
            end
            bpic_pkg::ST_CRN_RD, bpic_pkg::ST_PX_RD: begin
                o_cmd.inc_slot = 1'b1;
                o_cmd.capture = 1'b1;
            end
            bpic_pkg::ST_CRN_WAIT, bpic_pkg::ST_PX_WAIT: begin
                o_cmd.capture = 1'b1;
                o_cmd.clr_slot = 1'b1;
            end
            bpic_pkg::ST_CRN_WR: begin
                o_cmd.calc_corner = 1'b1;
                o_cmd.next_corner = 1'b1;
            end
            bpic_pkg::ST_PX_WR: begin
                o_cmd.calc_px = 1'b1;
                o_cmd.inc_slot = 1'b1;
                o_cmd.next_px = !i_sts.wr_left;
            end
            bpic_pkg::ST_RESP: begin
                o_cmd.do_mem = i_out_free;
                o_cmd.resp_kind = bpic_pkg::RESP_CLEAN;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

### hw/rtl/bpic_dp.sv
`timescale 1ns / 1ps

module bpic_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [bpic_pkg::SizeW-1:0]    i_cfg_data,
    input  logic [1:0]                    i_cmd,
    input  logic [7:0]                    i_col,
    input  logic [7:0]                    i_row,
    input  logic [7:0]                    i_pixel_byte,
    input  bpic_pkg::t_cmd                i_ctl,
    input  logic                          i_out_ready,
    output bpic_pkg::t_sts                o_sts,
    output logic                          o_out_free,
    output logic                          o_valid,
    output logic                          o_read_solid,
    output logic                          o_op_done,
    output logic                          o_out_of_range
);

    localparam int CW = bpic_pkg::ColW;
    localparam int RW = bpic_pkg::RowW;

    logic r_mem [0:(1 << bpic_pkg::AddrW)-1];
    logic r_rd_q;

    logic [bpic_pkg::SizeW-1:0] r_img_w, r_img_h;
    logic [1:0] r_cmd;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic r_solid_in, r_oor;

    logic [CW-1:0] r_cc;
    logic [RW-1:0] r_cr;
    logic [1:0] r_corner;
    logic r_corner_phase;
    logic [bpic_pkg::SlotW-1:0] r_slot;
    logic [bpic_pkg::SlotW-1:0] r_cap_slot;
    logic r_cap_vld;
    logic [bpic_pkg::NbN-1:0] r_nb;
    logic [bpic_pkg::NbN-1:0] r_new;

    logic r_valid, r_rs, r_done, r_oor_q;

    logic [CW-1:0] w_wm, w_wl;
    logic [RW-1:0] w_hm, w_hl;
    logic [CW:0] w_wcl;
    logic [RW:0] w_hcl;

    always_comb begin
        if (r_img_w < 9'd3) w_wcl = (CW+1)'(3);
        else if (r_img_w > 9'(bpic_pkg::MaxW)) w_wcl = (CW+1)'(bpic_pkg::MaxW);
        else w_wcl = (CW+1)'(r_img_w);
        if (r_img_h < 9'd3) w_hcl = (RW+1)'(3);
        else if (r_img_h > 9'(bpic_pkg::MaxH)) w_hcl = (RW+1)'(bpic_pkg::MaxH);
        else w_hcl = (RW+1)'(r_img_h);
        w_wm = CW'(w_wcl - 1'b1);
        w_wl = CW'(w_wcl - 2'd2);
        w_hm = RW'(w_hcl - 1'b1);
        w_hl = RW'(w_hcl - 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 9'd256;
            r_img_h <= 9'd256;
        end else if (i_cfg_we) begin
            if (i_cfg_index == bpic_pkg::REG_WIDTH) r_img_w <= i_cfg_data;
            else r_img_h <= i_cfg_data;
        end
    end

    // corner anchor and its neighbor slot coordinates
    logic [CW-1:0] w_kc, w_ac, w_bc;
    logic [RW-1:0] w_kr, w_ar, w_br;
    always_comb begin
        case (r_corner)
            2'd0: begin w_kc = '0;   w_kr = '0;
                w_ac = CW'(1); w_ar = '0; w_bc = '0; w_br = RW'(1); end
            2'd1: begin w_kc = w_wm; w_kr = '0;
                w_ac = w_wl; w_ar = '0; w_bc = w_wm; w_br = RW'(1); end
            2'd2: begin w_kc = '0;   w_kr = w_hm;
                w_ac = CW'(1); w_ar = w_hm; w_bc = '0; w_br = w_hl; end
            default: begin w_kc = w_wm; w_kr = w_hm;
                w_ac = w_wl; w_ar = w_hm; w_bc = w_wm; w_br = w_hl; end
        endcase
    end

    logic [CW-1:0] w_sc;
    logic [RW-1:0] w_sr;
    logic [CW-1:0] w_pc;
    logic [RW-1:0] w_pr;
    logic [bpic_pkg::SlotW-1:0] w_lim;
    always_comb begin
        w_pc = i_ctl.calc_corner ? r_cc : r_cc;
        w_pr = r_cr;
        case (r_slot)
            4'd1: begin w_sc = r_cc + 1'b1; w_sr = r_cr; end
            4'd2: begin w_sc = r_cc - 1'b1; w_sr = r_cr; end
            4'd3: begin w_sc = r_cc; w_sr = r_cr + 1'b1; end
            4'd4: begin w_sc = r_cc; w_sr = r_cr - 1'b1; end
            4'd5: begin w_sc = r_cc + 1'b1; w_sr = r_cr + 1'b1; end
            4'd6: begin w_sc = r_cc - 1'b1; w_sr = r_cr - 1'b1; end
            4'd7: begin w_sc = r_cc + 1'b1; w_sr = r_cr - 1'b1; end
            4'd8: begin w_sc = r_cc - 1'b1; w_sr = r_cr + 1'b1; end
            default: begin w_sc = r_cc; w_sr = r_cr; end
        endcase
        w_lim = 4'(bpic_pkg::NbN - 1);
    end

    // reads for corners: slot0 a, slot1 b
    logic [CW-1:0] w_rc;
    logic [RW-1:0] w_rr;
    always_comb begin
        if (i_ctl.first_corner || i_ctl.calc_px || i_ctl.next_px) begin
            w_rc = w_sc; w_rr = w_sr;
        end else begin
            w_rc = w_sc; w_rr = w_sr;
        end
    end

    logic [CW-1:0] w_mc;
    logic [RW-1:0] w_mr;
    always_comb begin
        if (r_corner_phase) begin
            if (r_slot == '0) begin w_mc = w_ac; w_mr = w_ar; end
            else begin w_mc = w_bc; w_mr = w_br; end
        end else begin
            w_mc = w_rc; w_mr = w_rr;
        end
    end

    // cleanup pixel rules, combinational over the captured neighborhood
    logic [bpic_pkg::NbN-1:0] w_rule;
    always_comb begin
        logic e, w, n, s, all4;
        logic d1a, d1b, d2a, d2b;
        w_rule = r_nb;
        e = r_nb[1]; w = r_nb[2]; n = r_nb[3]; s = r_nb[4];
        d1a = r_nb[5]; d1b = r_nb[6]; d2a = r_nb[7]; d2b = r_nb[8];
        all4 = e & w & n & s;
        if (!r_nb[0]) begin
            if (all4) w_rule[0] = 1'b1;
        end else begin
            if (!e && !w && !n && !s) w_rule[0] = 1'b0;
            if (all4) begin
                if (d1a && d1b && d2a && d2b) begin
                end else if (d1a && d1b && !d2a && !d2b) begin
                    w_rule[7] = 1'b1; w_rule[8] = 1'b1;
                end else if (d2a && d2b && !d1a && !d1b) begin
                    w_rule[5] = 1'b1; w_rule[6] = 1'b1;
                end
            end
            if (w_rule[1] && !w_rule[4] && !w_rule[3] && !w_rule[2]) begin
                w_rule[3] = 1'b1; w_rule[4] = 1'b1;
            end
            if (w_rule[4] && !w_rule[2] && !w_rule[1] && !w_rule[3]) begin
                w_rule[2] = 1'b1; w_rule[1] = 1'b1;
            end
            if (w_rule[2] && !w_rule[4] && !w_rule[3] && !w_rule[1]) begin
                w_rule[3] = 1'b1; w_rule[4] = 1'b1;
            end
            if (w_rule[3] && !w_rule[4] && !w_rule[1] && !w_rule[2]) begin
                w_rule[2] = 1'b1; w_rule[1] = 1'b1;
            end
        end
    end

    logic [bpic_pkg::NbN-1:0] w_diff;
    assign w_diff = r_new ^ r_nb;
    logic w_wr_now;
    assign w_wr_now = (r_slot <= w_lim) && w_diff[r_slot];
    assign o_sts.wr_left = (r_slot < w_lim);
    assign o_sts.slot_last = r_corner_phase ? (r_slot == 4'd1) : (r_slot == w_lim);
    assign o_sts.corner_last = (r_corner == 2'd3);
    assign o_sts.px_last = (r_cc == w_wl) && (r_cr == w_hl);
    assign o_out_free = !r_valid || i_out_ready;

    logic w_corner_wr, w_corner_val;
    assign w_corner_wr = (r_nb[0] == r_nb[1]);
    assign w_corner_val = r_nb[0];

    // single memory write port
    logic w_we, w_wd;
    logic [bpic_pkg::AddrW-1:0] w_wa;
    always_comb begin
        w_we = 1'b0;
        w_wa = {r_row, r_col};
        w_wd = r_solid_in;
        if (i_ctl.do_mem && i_ctl.resp_kind == bpic_pkg::RESP_ITEM
            && r_cmd == bpic_pkg::CMD_LOAD && !r_oor) begin
            w_we = 1'b1;
        end else if (i_ctl.calc_corner) begin
            w_we = w_corner_wr;
            w_wa = {w_kr, w_kc};
            w_wd = w_corner_val;
        end else if (i_ctl.calc_px && r_slot == '0) begin
            w_we = (w_rule[0] != r_nb[0]);
            w_wa = {w_pr, w_pc};
            w_wd = w_rule[0];
        end else if (i_ctl.calc_px) begin
            w_we = w_wr_now;
            w_wa = {w_sr, w_sc};
            w_wd = r_new[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot <= '0;
            r_corner <= '0;
            r_corner_phase <= 1'b0;
            r_cap_vld <= 1'b0;
        end else begin
            if (i_ctl.do_mem) r_valid <= 1'b1;
            else if (i_out_ready) r_valid <= 1'b0;
            r_cap_vld <= i_ctl.capture && !(i_ctl.clr_slot);
            if (i_ctl.clr_slot || i_ctl.next_corner || (i_ctl.calc_px && !o_sts.wr_left)) begin
                r_slot <= '0;
            end else if (i_ctl.inc_slot) begin
                r_slot <= r_slot + 1'b1;
            end
            if (i_ctl.load_item) begin
                r_corner <= '0;
                r_corner_phase <= (i_cmd == bpic_pkg::CMD_CLEAN);
            end else if (i_ctl.next_corner) begin
                r_corner <= r_corner + 1'b1;
                if (r_corner == 2'd3) r_corner_phase <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_q <= r_mem[{w_mr, w_mc}];
        r_cap_slot <= r_slot;
        if (r_cap_vld) r_nb[r_cap_slot] <= r_rd_q;
        if (i_ctl.load_item) begin
            r_cmd <= i_cmd;
            r_col <= i_col;
            r_row <= i_row;
            r_solid_in <= (i_pixel_byte == 8'd1);
            r_oor <= ({1'b0, i_col} >= w_wcl) || ({1'b0, i_row} >= w_hcl);
            r_cc <= CW'(1);
            r_cr <= RW'(1);
        end else if (i_ctl.next_px) begin
            if (r_cc == w_wl) begin
                r_cc <= CW'(1);
                r_cr <= r_cr + 1'b1;
            end else begin
                r_cc <= r_cc + 1'b1;
            end
        end
        if (w_we) r_mem[w_wa] <= w_wd;
        if (i_ctl.calc_px && r_slot == '0) r_new <= w_rule;
        if (i_ctl.do_mem) begin
            if (i_ctl.resp_kind == bpic_pkg::RESP_CLEAN) begin
                r_rs <= 1'b0;
                r_done <= 1'b1;
                r_oor_q <= 1'b0;
            end else if (r_cmd == bpic_pkg::CMD_LOAD || r_cmd == bpic_pkg::CMD_READ) begin
                r_done <= !r_oor;
                r_oor_q <= r_oor;
                if (r_cmd == bpic_pkg::CMD_READ && !r_oor) r_rs <= r_mem[{r_row, r_col}];
                else r_rs <= 1'b0;
            end else begin
                r_rs <= 1'b0;
                r_done <= 1'b0;
                r_oor_q <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_read_solid = r_rs;
    assign o_op_done = r_done;
    assign o_out_of_range = r_oor_q;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int CycleLimit = 3000000;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] pbyte;
    } t_item;

    typedef struct packed {
        logic rd;
        logic done;
        logic oor;
    } t_resp;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [0:0] i_cfg_index = '0;
    logic [8:0] i_cfg_data = '0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_cmd = '0;
    logic [7:0] i_col = '0;
    logic [7:0] i_row = '0;
    logic [7:0] i_pixel_byte = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic       o_read_solid;
    logic       o_op_done;
    logic       o_out_of_range;

    binary_pore_image_cleanup u_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_item pending_items[$];
    t_resp expected_resp[$];
    int    n_errors = 0;
    int    n_cycles = 0;

    // image as the block should hold it
    logic  img[0:65535];
    int    model_w_reg = 256;
    int    model_h_reg = 256;

    // stimulus side: which pixels have been loaded
    bit    loaded[0:65535];
    int    loaded_list[$];
    int    gen_w = 256;
    int    gen_h = 256;

    function automatic int clamp_size(int v);
        if (v < 3) return 3;
        if (v > 256) return 256;
        return v;
    endfunction

    function automatic logic pget(int c, int r);
        return img[r * 256 + c];
    endfunction

    task automatic pset(int c, int r, logic v);
        img[r * 256 + c] = v;
    endtask

    task automatic settle_corner(int cc, int cr, int ac, int ar, int bc, int br);
        logic a, b;
        a = pget(ac, ar);
        b = pget(bc, br);
        if (a && b) pset(cc, cr, 1'b1);
        if (!a && !b) pset(cc, cr, 1'b0);
    endtask

    task automatic fix_solid_px(int c, int r, logic all4);
        logic d1a, d1b, d2a, d2b;
        if (!pget(c+1, r) && !pget(c-1, r) && !pget(c, r+1) && !pget(c, r-1))
            pset(c, r, 1'b0);
        if (all4) begin
            d1a = pget(c+1, r+1);
            d1b = pget(c-1, r-1);
            d2a = pget(c+1, r-1);
            d2b = pget(c-1, r+1);
            if ((d1a && d1b) && (d2a && d2b)) begin
            end else if ((d1a && d1b) && (!d2a && !d2b)) begin
                pset(c+1, r-1, 1'b1);
                pset(c-1, r+1, 1'b1);
            end else if ((d2a && d2b) && (!d1a && !d1b)) begin
                pset(c+1, r+1, 1'b1);
                pset(c-1, r-1, 1'b1);
            end
        end
        if (pget(c+1, r) && !pget(c, r-1) && !pget(c, r+1) && !pget(c-1, r)) begin
            pset(c, r+1, 1'b1);
            pset(c, r-1, 1'b1);
        end
        if (pget(c, r-1) && !pget(c-1, r) && !pget(c+1, r) && !pget(c, r+1)) begin
            pset(c-1, r, 1'b1);
            pset(c+1, r, 1'b1);
        end
        if (pget(c-1, r) && !pget(c, r-1) && !pget(c, r+1) && !pget(c+1, r)) begin
            pset(c, r+1, 1'b1);
            pset(c, r-1, 1'b1);
        end
        if (pget(c, r+1) && !pget(c, r-1) && !pget(c+1, r) && !pget(c-1, r)) begin
            pset(c-1, r, 1'b1);
            pset(c+1, r, 1'b1);
        end
    endtask

    task automatic cleanup_image(int w, int h);
        logic all4;
        settle_corner(0, 0, 1, 0, 0, 1);
        settle_corner(w-1, 0, w-2, 0, w-1, 1);
        settle_corner(0, h-1, 1, h-1, 0, h-2);
        settle_corner(w-1, h-1, w-2, h-1, w-1, h-2);
        for (int r = 1; r + 1 < h; r++) begin
            for (int c = 1; c + 1 < w; c++) begin
                all4 = pget(c+1, r) && pget(c-1, r) && pget(c, r+1) && pget(c, r-1);
                if (pget(c, r)) fix_solid_px(c, r, all4);
                else if (all4) pset(c, r, 1'b1);
            end
        end
    endtask

    task automatic predict_image_op(t_item it);
        t_resp rsp;
        int w, h;
        w = clamp_size(model_w_reg);
        h = clamp_size(model_h_reg);
        rsp = '0;
        if (it.cmd == bpic_pkg::CMD_CLEAN) begin
            cleanup_image(w, h);
            rsp.done = 1'b1;
        end else if (it.cmd == bpic_pkg::CMD_LOAD || it.cmd == bpic_pkg::CMD_READ) begin
            if (it.col >= w || it.row >= h) begin
                rsp.oor = 1'b1;
            end else if (it.cmd == bpic_pkg::CMD_LOAD) begin
                pset(it.col, it.row, it.pbyte == 8'd1);
                rsp.done = 1'b1;
            end else begin
                rsp.rd = pget(it.col, it.row);
                rsp.done = 1'b1;
            end
        end
        expected_resp.push_back(rsp);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch: %s got %0d expected %0d at cycle %0d", what, got, want, n_cycles);
        n_errors++;
    endtask

    // stimulus generation
    task automatic queue_item(logic [1:0] cmd, int col, int row, logic [7:0] pbyte);
        t_item it;
        int a;
        it.cmd = cmd;
        it.col = col[7:0];
        it.row = row[7:0];
        it.pbyte = pbyte;
        pending_items.push_back(it);
        if (cmd == bpic_pkg::CMD_LOAD && col < gen_w && row < gen_h) begin
            a = row * 256 + col;
            if (!loaded[a]) begin
                loaded[a] = 1'b1;
                loaded_list.push_back(a);
            end
        end
    endtask

    function automatic logic [7:0] rand_pixel_byte();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5) return 8'd1;
        if (k < 8) return 8'd0;
        return 8'($urandom);
    endfunction

    task automatic fill_region();
        for (int r = 0; r < gen_h; r++)
            for (int c = 0; c < gen_w; c++)
                if (!loaded[r * 256 + c])
                    queue_item(bpic_pkg::CMD_LOAD, c, r, rand_pixel_byte());
    endtask

    task automatic queue_random(int n, bit allow_clean);
        int k, a, c, r;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
                queue_item(bpic_pkg::CMD_LOAD, $urandom_range(0, gen_w - 1),
                           $urandom_range(0, gen_h - 1), rand_pixel_byte());
            end else if (k < 75) begin
                a = -1;
                for (int t = 0; t < 8 && a < 0; t++) begin
                    if (loaded_list.size() > 0) begin
                        a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                        if ((a % 256) >= gen_w || (a / 256) >= gen_h) a = -1;
                    end
                end
                if (a >= 0) queue_item(bpic_pkg::CMD_READ, a % 256, a / 256, 8'($urandom));
                else queue_item(bpic_pkg::CMD_LOAD, 0, 0, rand_pixel_byte());
            end else if (k < 85) begin
                c = $urandom_range(0, 255);
                r = $urandom_range(0, 255);
                if (gen_w < 256 && (gen_h == 256 || $urandom_range(0, 1) == 1)) begin
                    c = $urandom_range(gen_w, 255);
                end else if (gen_h < 256) begin
                    r = $urandom_range(gen_h, 255);
                end
                if (c < gen_w && r < gen_h) begin
                    queue_item(bpic_pkg::CMD_LOAD, c, r, 8'($urandom));
                end else begin
                    queue_item($urandom_range(0, 1) ? bpic_pkg::CMD_LOAD : bpic_pkg::CMD_READ,
                               c, r, 8'($urandom));
                end
            end else if (k < 89) begin
                queue_item(CMD_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                           8'($urandom));
            end else if (allow_clean && k < 97) begin
                fill_region();
                queue_item(bpic_pkg::CMD_CLEAN, $urandom_range(0, 255),
                           $urandom_range(0, 255), 8'($urandom));
            end else begin
                queue_item(bpic_pkg::CMD_LOAD, $urandom_range(0, gen_w - 1),
                           $urandom_range(0, gen_h - 1), rand_pixel_byte());
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_valid || expected_resp.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [8:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bpic_pkg::REG_WIDTH) model_w_reg = val;
        else model_h_reg = val;
    endtask

    task automatic run_phase(logic [8:0] wv, logic [8:0] hv, int n, bit allow_clean);
        wait_drained();
        write_reg(bpic_pkg::REG_WIDTH, wv);
        write_reg(bpic_pkg::REG_HEIGHT, hv);
        gen_w = clamp_size(wv);
        gen_h = clamp_size(hv);
        queue_random(n, allow_clean);
    endtask

    // driver
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        t_item nxt;
        bit    holding;
        n_cycles++;
        if (n_cycles > CycleLimit) begin
            $display("timeout at cycle %0d", n_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n) begin
            holding = i_valid;
            if (i_valid && o_ready) begin
                predict_image_op('{i_cmd, i_col, i_row, i_pixel_byte});
                holding = 1'b0;
            end
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    nxt = pending_items.pop_front();
                    i_cmd <= nxt.cmd;
                    i_col <= nxt.col;
                    i_row <= nxt.row;
                    i_pixel_byte <= nxt.pbyte;
                    i_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int stall_mode = 0;
    int mode_left = 0;

    always @(posedge i_clk) begin
        t_resp want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_resp.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    want = expected_resp.pop_front();
                    if (o_read_solid !== want.rd)
                        report_mismatch("read_solid", o_read_solid, want.rd);
                    if (o_op_done !== want.done)
                        report_mismatch("op_done", o_op_done, want.done);
                    if (o_out_of_range !== want.oor)
                        report_mismatch("out_of_range", o_out_of_range, want.oor);
                end
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(32, 300);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: begin
                    i_ready <= 1'b1;
                end
                1: begin
                    i_ready <= $urandom_range(0, 1);
                end
                default: begin
                    i_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes at full size
        queue_item(bpic_pkg::CMD_LOAD, 0, 0, 8'd1);
        queue_item(bpic_pkg::CMD_LOAD, 255, 255, 8'd1);
        queue_item(bpic_pkg::CMD_LOAD, 255, 0, 8'd255);
        queue_item(bpic_pkg::CMD_LOAD, 0, 255, 8'd0);
        queue_item(bpic_pkg::CMD_LOAD, 170, 85, 8'd2);
        queue_item(bpic_pkg::CMD_READ, 0, 0, 8'd0);
        queue_item(bpic_pkg::CMD_READ, 255, 255, 8'd255);
        queue_item(bpic_pkg::CMD_READ, 255, 0, 8'd0);
        queue_item(bpic_pkg::CMD_READ, 0, 255, 8'd0);
        queue_item(bpic_pkg::CMD_READ, 170, 85, 8'd0);
        queue_item(CMD_NONE, 255, 255, 8'd255);

        // directed: 3x3 corners, lonely pixel, out of range and cleanup fields ignored
        run_phase(9'd0, 9'd2, 0, 1'b0);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                queue_item(bpic_pkg::CMD_LOAD, c, r, (r == 1 && c == 1) ? 8'd1 : 8'd0);
        queue_item(bpic_pkg::CMD_LOAD, 1, 0, 8'd1);
        queue_item(bpic_pkg::CMD_LOAD, 0, 1, 8'd1);
        queue_item(bpic_pkg::CMD_LOAD, 3, 0, 8'd1);
        queue_item(bpic_pkg::CMD_READ, 0, 3, 8'd0);
        queue_item(bpic_pkg::CMD_CLEAN, 255, 255, 8'd255);
        queue_item(bpic_pkg::CMD_READ, 0, 0, 8'd0);
        queue_item(bpic_pkg::CMD_READ, 1, 1, 8'd0);
        queue_item(bpic_pkg::CMD_READ, 2, 2, 8'd0);
        queue_random(200, 1'b1);

        run_phase(9'd5, 9'd4, 250, 1'b1);
        run_phase(9'd8, 9'd8, 250, 1'b1);
        run_phase(9'd511, 9'd300, 220, 1'b0);
        run_phase(9'd3, 9'd256, 200, 1'b0);
        run_phase(9'd7, 9'd3, 200, 1'b1);

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
